[hw/rtl/lfls_pkg.sv]
// shared types and constants for the led matrix frame loader and scanner
`default_nettype none

package lfls_pkg;

  // item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // serial framing bytes
  localparam logic [7:0] HEADER_FIRST  = 8'hCA;
  localparam logic [7:0] HEADER_SECOND = 8'hFE;
  localparam logic [7:0] CMD_SWAP      = 8'h00;
  localparam logic [7:0] CMD_LOAD      = 8'h01;

  // fixed field widths
  localparam int ROW_W    = 4;
  localparam int COLUMN_W = 7;

  // result queue depth
  localparam int QUEUE_DEPTH = 3;

  // scan item in flight while the frame memory read completes
  typedef struct packed {
    logic                fill_ok;
    logic [COLUMN_W-1:0] column_index;
    logic                row_done;
    logic [2:0]          row_address;
    logic                high_bank;
    logic                low_bank;
  } scan_info_t;

  // one result item
  typedef struct packed {
    logic                pixel_on;
    logic [COLUMN_W-1:0] column_index;
    logic                row_done;
    logic [2:0]          row_address;
    logic                high_bank;
    logic                low_bank;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/lfls_frame_mem.sv]
// single-bit frame memory, one write port and one registered read port
`default_nettype none

module lfls_frame_mem #(
  parameter int DEPTH = 3360
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic                     wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                          rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lfls_ctrl.sv]
// byte parser, scan counters and frame memory address generation
`default_nettype none

module lfls_ctrl #(
  parameter int ROW_COUNT    = 15,
  parameter int COLUMN_COUNT = 112,
  localparam int FP = ROW_COUNT * COLUMN_COUNT,
  localparam int AW = $clog2(2 * FP)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic                  opcode,
  input  wire logic [7:0]            rx_byte,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic                       wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  output logic                       s1_valid,
  output lfls_pkg::scan_info_t       s1_info
);

  localparam int PW_RAW = $clog2(FP + 1);
  localparam int PW     = (PW_RAW < 2) ? 2 : PW_RAW;

  localparam logic [PW-1:0] FP_P    = PW'(FP);
  localparam logic [PW-1:0] COLS_P  = PW'(COLUMN_COUNT);
  localparam logic [AW-1:0] FP_A    = AW'(FP);
  localparam logic [lfls_pkg::ROW_W:0]    ROWS_L = (lfls_pkg::ROW_W + 1)'(ROW_COUNT);
  localparam logic [lfls_pkg::COLUMN_W:0] COLS_L = (lfls_pkg::COLUMN_W + 1)'(COLUMN_COUNT);

  // parser state
  logic          front_select;
  logic [PW-1:0] parse_count;
  logic [7:0]    first_header_byte;
  logic          load_active;
  // scan state
  logic [lfls_pkg::ROW_W-1:0]    scan_row;
  logic [lfls_pkg::COLUMN_W-1:0] scan_column;
  // written extent of each frame since reset
  logic [PW-1:0] fill [2];

  logic                          is_byte;
  logic                          is_tick;
  logic [lfls_pkg::ROW_W-1:0]    row;
  logic [lfls_pkg::COLUMN_W-1:0] col;
  logic [PW-1:0]                 pix_idx;
  logic                          done;
  logic [PW-1:0]                 load_next;
  logic                          back_sel;
  lfls_pkg::scan_info_t          info_next;

  assign is_byte  = take && (opcode == lfls_pkg::OP_BYTE);
  assign is_tick  = take && (opcode == lfls_pkg::OP_TICK);
  assign back_sel = ~front_select;

  always_comb begin
    row     = ({1'b0, scan_row} >= ROWS_L) ? '0 : scan_row;
    col     = ({1'b0, scan_column} >= COLS_L) ? '0 : scan_column;
    pix_idx = PW'(row) * COLS_P + PW'(col);
    done    = ({1'b0, col} + 1'b1) >= COLS_L;
    info_next.fill_ok      = pix_idx < fill[front_select];
    info_next.column_index = col;
    info_next.row_done     = done;
    info_next.row_address  = done ? row[2:0] : 3'd0;
    info_next.high_bank    = done && row[3];
    info_next.low_bank     = done && !row[3];
  end

  assign load_next = parse_count + 1'b1;

  assign rd_en   = is_tick;
  assign rd_addr = (front_select ? FP_A : '0) + AW'(pix_idx);
  assign wr_en   = is_byte && load_active;
  assign wr_addr = (back_sel ? FP_A : '0) + AW'(parse_count);
  assign wr_data = rx_byte != 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_select      <= 1'b0;
      parse_count       <= '0;
      first_header_byte <= '0;
      load_active       <= 1'b0;
      scan_row          <= '0;
      scan_column       <= '0;
      fill[0]           <= '0;
      fill[1]           <= '0;
      s1_valid          <= 1'b0;
    end else begin
      s1_valid <= is_tick;
      if (is_tick) begin
        if (done) begin
          scan_row    <= ({1'b0, row} + 1'b1 == ROWS_L) ? '0 : row + 1'b1;
          scan_column <= '0;
        end else begin
          scan_row    <= row;
          scan_column <= col + 1'b1;
        end
      end
      if (is_byte) begin
        if (load_active) begin
          // loads always start at pixel zero, so the extent only grows
          if (load_next > fill[back_sel]) begin
            fill[back_sel] <= load_next;
          end
          if (load_next >= FP_P) begin
            load_active <= 1'b0;
            parse_count <= '0;
          end else begin
            parse_count <= load_next;
          end
        end else if (parse_count == PW'(0)) begin
          first_header_byte <= rx_byte;
          parse_count       <= PW'(1);
        end else if (parse_count == PW'(1)) begin
          if (first_header_byte == lfls_pkg::HEADER_FIRST
              && rx_byte == lfls_pkg::HEADER_SECOND) begin
            parse_count <= PW'(2);
          end else begin
            parse_count <= '0;
          end
        end else begin
          parse_count <= '0;
          if (rx_byte == lfls_pkg::CMD_SWAP) begin
            front_select <= ~front_select;
            scan_row     <= '0;
            scan_column  <= '0;
          end else if (rx_byte == lfls_pkg::CMD_LOAD) begin
            load_active <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      s1_info <= info_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lfls_out_q.sv]
// small result queue that decouples the scan pipeline from the receiver
`default_nettype none

module lfls_out_q (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire lfls_pkg::scan_info_t push_info,
  input  wire logic                 push_pixel,
  input  wire logic                 pop,
  output logic                      head_valid,
  output lfls_pkg::result_t         head,
  output logic [1:0]                count
);

  localparam logic [1:0] LAST = 2'(lfls_pkg::QUEUE_DEPTH - 1);

  lfls_pkg::result_t entries [lfls_pkg::QUEUE_DEPTH];
  logic [1:0]        wr_ptr;
  logic [1:0]        rd_ptr;
  lfls_pkg::result_t push_item;
  logic              do_pop;

  always_comb begin
    push_item.pixel_on     = push_info.fill_ok && push_pixel;
    push_item.column_index = push_info.column_index;
    push_item.row_done     = push_info.row_done;
    push_item.row_address  = push_info.row_address;
    push_item.high_bank    = push_info.high_bank;
    push_item.low_bank     = push_info.low_bank;
  end

  assign head_valid = count != 2'd0;
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/led_matrix_frame_loader_scanner.sv]
// top level of the double-buffered led matrix frame loader and row scanner
// usage:
//   request channel (req_valid / req_stall) takes one item per cycle while
//   req_stall is low: opcode 0 carries a serial byte for the CA FE framed
//   parser, opcode 1 is a scan tick; result channel (res_valid / res_stall)
//   gives one item per scan tick and nothing for serial bytes: pixel, column
//   and the row selects on the last column of a row
//   path: a tick's read passes the frame memory read register, then the
//   result queue entry, before its result can reach the result channel
//   throughput: one item per cycle while req_stall is low, set by the single
//   read and single write port of the frame memory; bytes and ticks mix freely
//   a three-entry result queue absorbs receiver stalls; once it and the read
//   stage hold three results, req_stall rises until one is taken
//   reset: parser idle, front frame 0, scan at row 0 column 0; the frame
//   memory is not swept, a per-frame written-extent count makes pixels never
//   loaded since reset read as off, so items are taken from the first cycle
`default_nettype none

module led_matrix_frame_loader_scanner #(
  parameter int ROW_COUNT    = 15,
  parameter int COLUMN_COUNT = 112
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // request channel
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic       opcode,
  input  wire logic [7:0] rx_byte,
  // result channel
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic            pixel_on,
  output logic [6:0]      column_index,
  output logic            row_done,
  output logic [2:0]      row_address,
  output logic            high_bank,
  output logic            low_bank
);

  localparam int DEPTH = 2 * ROW_COUNT * COLUMN_COUNT;
  localparam int AW    = $clog2(DEPTH);

  logic                 take;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 rd_data;
  logic                 s1_valid;
  lfls_pkg::scan_info_t s1_info;
  lfls_pkg::result_t    head;
  logic [1:0]           q_count;
  logic [2:0]           occupancy;

  // results in flight: queued plus the read in progress
  assign occupancy = {1'b0, q_count} + 3'(s1_valid);
  assign req_stall = occupancy >= 3'(lfls_pkg::QUEUE_DEPTH);
  assign take      = req_valid && !req_stall;

  // parser, scan counters and address generation
  lfls_ctrl #(
    .ROW_COUNT   (ROW_COUNT),
    .COLUMN_COUNT(COLUMN_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .opcode  (opcode),
    .rx_byte (rx_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .s1_valid(s1_valid),
    .s1_info (s1_info)
  );

  // both frames in one memory, front/back chosen by a one-frame address offset
  lfls_frame_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // read data joins its scan info and waits for the receiver
  lfls_out_q u_q (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_info (s1_info),
    .push_pixel(rd_data),
    .pop       (!res_stall),
    .head_valid(res_valid),
    .head      (head),
    .count     (q_count)
  );

  assign pixel_on     = head.pixel_on;
  assign column_index = head.column_index;
  assign row_done     = head.row_done;
  assign row_address  = head.row_address;
  assign high_bank    = head.high_bank;
  assign low_bank     = head.low_bank;

endmodule

`default_nettype wire
